// ===== src/ked_pkg.sv =====
// Shared types and constants for the key event detector.
package ked_pkg;

    localparam int FLAG_W   = 7;
    localparam int TIME_W   = 16;
    localparam int DIV_W    = 8;
    localparam int LEVEL_W  = 4;
    localparam int KIDX_W   = 2;
    localparam int KEY_SLOTS = 1 << KIDX_W;
    localparam int CFG_IDX_W = 2;

    typedef logic [FLAG_W-1:0] flags_t;
    typedef logic [TIME_W-1:0] ktime_t;

    localparam flags_t FLG_HOLD   = 7'h01;
    localparam flags_t FLG_DOWN   = 7'h02;
    localparam flags_t FLG_UP     = 7'h04;
    localparam flags_t FLG_SINGLE = 7'h08;
    localparam flags_t FLG_DOUBLE = 7'h10;
    localparam flags_t FLG_LONG   = 7'h20;
    localparam flags_t FLG_REPEAT = 7'h40;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_CHECK = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_DIV  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_TIME   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_TIME = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_TIME = 2'd3;

    localparam logic [DIV_W-1:0] RST_SAMPLE_DIV  = 8'd20;
    localparam ktime_t           RST_LONG_TIME   = 16'd1000;
    localparam ktime_t           RST_REPEAT_TIME = 16'd100;
    localparam ktime_t           RST_DOUBLE_TIME = 16'd0;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_PRESSED  = 3'd1,
        PH_RELEASED = 3'd2,
        PH_SECOND   = 3'd3,
        PH_LONG     = 3'd4
    } phase_t;

    // Per-lane strobes for one accepted word.
    typedef struct packed {
        logic   tick;
        logic   sample;
        logic   clear;
        flags_t mask;
    } lane_ctrl_t;

    typedef struct packed {
        ktime_t long_time;
        ktime_t rpt_time;
        ktime_t dbl_time;
    } key_times_t;

endpackage

// ===== src/ked_req_if.sv =====
// Request channel: tick and check words.
interface ked_req_if;
    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic [ked_pkg::LEVEL_W-1:0]   keys_pressed;
    logic [ked_pkg::KIDX_W-1:0]    key_index;
    logic [ked_pkg::FLAG_W-1:0]    flag_mask;

    modport source (output valid, opcode, keys_pressed, key_index, flag_mask, input ready);
    modport sink   (input valid, opcode, keys_pressed, key_index, flag_mask, output ready);
endinterface

// ===== src/ked_rsp_if.sv =====
// Response channel: check result words.
interface ked_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        check_hit;
    logic [ked_pkg::FLAG_W-1:0]  key_flags;

    modport source (output valid, check_hit, key_flags, input ready);
    modport sink   (input valid, check_hit, key_flags, output ready);
endinterface

// ===== src/ked_cfg_if.sv =====
// Configuration write channel.
interface ked_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ked_pkg::CFG_IDX_W-1:0]  index;
    logic [ked_pkg::TIME_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/key_event_detector_core.sv =====
// Top level of the key event detector: config registers, tick divider, key lanes, merge.
//
// Channels: req takes one word per cycle. A tick word (opcode 0) carries the
// pressed level of each key; every key timer counts down, and every
// sample_divisor-th tick the keys are sampled and their phase machines step.
// A check word (opcode 1) names a key and a flag mask; the answer is whether
// any masked flag is set, and the masked flags are cleared unless the mask is
// exactly the hold bit. Every word, tick or check, yields one rsp word (ticks
// answer zero). cfg writes sample_divisor, long_press_time, repeat_time and
// double_click_time by index, always ready; write only while idle.
// The rsp word is registered and appears in the cycle after its req word is taken.
// Throughput: one word per cycle; all key lanes update in parallel in the
// accept cycle, and the merge stage's single output register sets the pace.
// Stall: while rsp is stalled and holds a word, req is not ready; the output
// register frees the cycle the held word is taken, so no bubble appears.
// Reset: all keys idle, flags and timers zero, registers at their defaults
// (20, 1000, 100, 0); the block accepts words right after reset.
module key_event_detector_core #(
    parameter int NUM_KEYS = 4
)
(
    input  logic         clk,
    input  logic         rst_n,
    ked_req_if.sink      req,
    ked_rsp_if.source    rsp,
    ked_cfg_if.sink      cfg
);

    logic [ked_pkg::DIV_W-1:0] sample_div_reg, sample_div_next;
    ked_pkg::key_times_t       times_reg, times_next;
    logic [ked_pkg::DIV_W-1:0] tick_count_reg, tick_count_next;
    logic [ked_pkg::DIV_W-1:0] tick_inc;

    logic                           accept;
    logic                           is_tick;
    logic                           sample;
    logic                           clear_en;
    logic                           in_ready;
    ked_pkg::flags_t [NUM_KEYS-1:0] lane_flags;

    assign cfg.ready = 1'b1;
    assign req.ready = in_ready;
    assign accept    = req.valid && in_ready;
    assign is_tick   = (req.opcode == ked_pkg::OP_TICK);

    always_comb
    begin
        sample_div_next = sample_div_reg;
        times_next      = times_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                ked_pkg::CFG_SAMPLE_DIV:  sample_div_next = cfg.data[ked_pkg::DIV_W-1:0];
                ked_pkg::CFG_LONG_TIME:   times_next.long_time = cfg.data;
                ked_pkg::CFG_REPEAT_TIME: times_next.rpt_time  = cfg.data;
                ked_pkg::CFG_DOUBLE_TIME: times_next.dbl_time  = cfg.data;
                default:                  sample_div_next = sample_div_reg;
            endcase
        end
    end

    // Count ticks; sample once the count reaches the divisor, then restart.
    assign tick_inc = tick_count_reg + 1'b1;
    assign sample   = (tick_inc >= sample_div_reg);

    always_comb
    begin
        tick_count_next = tick_count_reg;
        if (accept && is_tick)
            tick_count_next = sample ? '0 : tick_inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_div_reg     <= ked_pkg::RST_SAMPLE_DIV;
            times_reg.long_time <= ked_pkg::RST_LONG_TIME;
            times_reg.rpt_time  <= ked_pkg::RST_REPEAT_TIME;
            times_reg.dbl_time  <= ked_pkg::RST_DOUBLE_TIME;
            tick_count_reg     <= '0;
        end
        else
        begin
            sample_div_reg <= sample_div_next;
            times_reg      <= times_next;
            tick_count_reg <= tick_count_next;
        end
    end

    for (genvar k = 0; k < NUM_KEYS; k++)
    begin : g_key
        ked_pkg::lane_ctrl_t ctrl;
        logic                level;

        if (k < ked_pkg::LEVEL_W)
        begin : g_pin
            assign level = req.keys_pressed[k];
        end
        else
        begin : g_nopin
            assign level = 1'b0;
        end

        assign ctrl.tick   = accept && is_tick;
        assign ctrl.sample = sample;
        assign ctrl.clear  = clear_en && (32'(req.key_index) == k);
        assign ctrl.mask   = req.flag_mask;

        ked_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl),
            .level (level),
            .times (times_reg),
            .flags (lane_flags[k])
        );
    end

    ked_merge #(
        .NUM_KEYS (NUM_KEYS)
    ) u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .is_check   (!is_tick),
        .key_index  (req.key_index),
        .mask       (req.flag_mask),
        .lane_flags (lane_flags),
        .out_ready  (rsp.ready),
        .in_ready   (in_ready),
        .clear_en   (clear_en),
        .out_valid  (rsp.valid),
        .out_hit    (rsp.check_hit),
        .out_flags  (rsp.key_flags)
    );

endmodule

// ===== src/ked_lane.sv =====
// One key lane: level, timer, phase machine and sticky event flags.
module ked_lane
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ked_pkg::lane_ctrl_t  ctrl,
    input  logic                 level,
    input  ked_pkg::key_times_t  times,
    output ked_pkg::flags_t      flags
);

    ked_pkg::phase_t phase_reg, phase_next;
    ked_pkg::ktime_t timer_reg, timer_next;
    ked_pkg::flags_t flags_reg, flags_next;
    logic            level_reg, level_next;
    ked_pkg::ktime_t timer_dec;
    logic            timer_zero;

    // Timer counts down on every tick before the sample looks at it.
    assign timer_dec  = (timer_reg != '0) ? timer_reg - 1'b1 : timer_reg;
    assign timer_zero = (timer_dec == '0);

    always_comb
    begin
        phase_next = phase_reg;
        if (ctrl.tick && ctrl.sample)
        begin
            unique case (phase_reg)
                ked_pkg::PH_PRESSED:
                begin
                    if (!level)
                        phase_next = ked_pkg::PH_RELEASED;
                    else if (timer_zero)
                        phase_next = ked_pkg::PH_LONG;
                end
                ked_pkg::PH_RELEASED:
                begin
                    if (level)
                        phase_next = ked_pkg::PH_SECOND;
                    else if (timer_zero)
                        phase_next = ked_pkg::PH_IDLE;
                end
                ked_pkg::PH_SECOND:
                begin
                    if (!level)
                        phase_next = ked_pkg::PH_IDLE;
                end
                ked_pkg::PH_LONG:
                begin
                    if (!level)
                        phase_next = ked_pkg::PH_IDLE;
                end
                default:
                begin
                    if (level)
                        phase_next = ked_pkg::PH_PRESSED;
                end
            endcase
        end
    end

    always_comb
    begin
        timer_next = timer_reg;
        flags_next = flags_reg;
        level_next = level_reg;
        if (ctrl.tick)
        begin
            timer_next = timer_dec;
            if (ctrl.sample)
            begin
                level_next = level;
                if (level)
                    flags_next = flags_next | ked_pkg::FLG_HOLD;
                else
                    flags_next = flags_next & ~ked_pkg::FLG_HOLD;
                if (level && !level_reg)
                    flags_next = flags_next | ked_pkg::FLG_DOWN;
                if (!level && level_reg)
                    flags_next = flags_next | ked_pkg::FLG_UP;
                unique case (phase_reg)
                    ked_pkg::PH_PRESSED:
                    begin
                        if (!level)
                            timer_next = times.dbl_time;
                        else if (timer_zero)
                        begin
                            timer_next = times.rpt_time;
                            flags_next = flags_next | ked_pkg::FLG_LONG;
                        end
                    end
                    ked_pkg::PH_RELEASED:
                    begin
                        if (level)
                            flags_next = flags_next | ked_pkg::FLG_DOUBLE;
                        else if (timer_zero)
                            flags_next = flags_next | ked_pkg::FLG_SINGLE;
                    end
                    ked_pkg::PH_SECOND:
                    begin
                    end
                    ked_pkg::PH_LONG:
                    begin
                        if (level && timer_zero)
                        begin
                            timer_next = times.rpt_time;
                            flags_next = flags_next | ked_pkg::FLG_REPEAT;
                        end
                    end
                    default:
                    begin
                        if (level)
                            timer_next = times.long_time;
                    end
                endcase
            end
        end
        if (ctrl.clear)
            flags_next = flags_reg & ~ctrl.mask;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ked_pkg::PH_IDLE;
            timer_reg <= '0;
            flags_reg <= '0;
            level_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            timer_reg <= timer_next;
            flags_reg <= flags_next;
            level_reg <= level_next;
        end
    end

    assign flags = flags_reg;

endmodule

// ===== src/ked_merge.sv =====
// Merge stage: pick the named key's flags, form the answer, hold it in the output register.
module ked_merge #(
    parameter int NUM_KEYS = 4
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 accept,
    input  logic                                 is_check,
    input  logic [ked_pkg::KIDX_W-1:0]           key_index,
    input  ked_pkg::flags_t                      mask,
    input  ked_pkg::flags_t [NUM_KEYS-1:0]       lane_flags,
    input  logic                                 out_ready,
    output logic                                 in_ready,
    output logic                                 clear_en,
    output logic                                 out_valid,
    output logic                                 out_hit,
    output ked_pkg::flags_t                      out_flags
);

    ked_pkg::flags_t [ked_pkg::KEY_SLOTS-1:0] slot_flags;
    ked_pkg::flags_t sel_flags;
    logic            hit;
    logic            valid_reg, valid_next;
    logic            hit_reg, hit_next;
    ked_pkg::flags_t flags_reg, flags_next;

    // Slots with no lane read as zero, so a check on them answers zero.
    for (genvar s = 0; s < ked_pkg::KEY_SLOTS; s++)
    begin : g_slot
        if (s < NUM_KEYS)
        begin : g_lane
            assign slot_flags[s] = lane_flags[s];
        end
        else
        begin : g_none
            assign slot_flags[s] = '0;
        end
    end

    assign sel_flags = slot_flags[key_index];
    assign hit       = (sel_flags & mask) != '0;
    assign clear_en  = accept && is_check && hit && (mask != ked_pkg::FLG_HOLD);
    assign in_ready  = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        hit_next   = hit_reg;
        flags_next = flags_reg;
        if (accept)
        begin
            valid_next = 1'b1;
            hit_next   = is_check && hit;
            flags_next = is_check ? sel_flags : '0;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        hit_reg   <= hit_next;
        flags_reg <= flags_next;
    end

    assign out_valid = valid_reg;
    assign out_hit   = hit_reg;
    assign out_flags = flags_reg;

endmodule
